// ----- hw/rtl/gst_pkg.sv -----
// ----------------------------------------------------------------------------
// gst_pkg
// Shared widths, register indexes and the group descriptor type.
// ----------------------------------------------------------------------------
package gst_pkg;

    localparam int MAX_GROUP = 64;
    localparam int DATA_W    = 24;
    localparam int TH_W      = 23;
    localparam int GS_W      = 7;
    localparam int CNT_W     = 7;
    localparam int SUM_W     = 53;
    localparam int NORM_W    = 27;
    localparam int FACT_W    = 17;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int BUF_DEPTH = 2 * MAX_GROUP;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 23;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             bank;
    } desc_t;

endpackage

// ----- hw/rtl/gst_ram.sv -----
// ----------------------------------------------------------------------------
// gst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/gst_front.sv -----
// ----------------------------------------------------------------------------
// gst_front
// Accepts elements, writes them to the current buffer bank and accumulates
// the sum of squares; hands each completed group to the queue.
// ----------------------------------------------------------------------------
module gst_front import gst_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic [GS_W-1:0]          group_size,
    input  logic                     q_full,
    output logic                     push,
    output desc_t                    push_desc,
    output logic                     buf_we,
    output logic [ADDR_W-1:0]        buf_waddr,
    output logic [DATA_W-1:0]        buf_wdata
);

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             bank_reg, bank_next;

    logic [DATA_W-1:0]   mag;
    logic [2*DATA_W-1:0] sq;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    cnt_add;
    logic [CNT_W-1:0]    eff_size;
    logic                accept;
    logic                done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (group_size == '0)
            eff_size = CNT_W'(1);
        else if (group_size > CNT_W'(MAX_GROUP))
            eff_size = CNT_W'(MAX_GROUP);
        else
            eff_size = group_size;
    end

    assign mag     = value[DATA_W-1] ? DATA_W'(-value) : DATA_W'(value);
    assign sq      = mag * mag;
    assign sum_add = sum_reg + SUM_W'(sq);
    assign cnt_add = fill_reg + CNT_W'(1);
    assign done    = cnt_add >= eff_size;

    assign buf_we    = accept;
    assign buf_waddr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign buf_wdata = value;

    assign push           = accept && done;
    assign push_desc.sum  = sum_add;
    assign push_desc.cnt  = cnt_add;
    assign push_desc.bank = bank_reg;

    always_comb
    begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (done)
            begin
                fill_next = '0;
                sum_next  = '0;
                bank_next = !bank_reg;
            end
            else
            begin
                fill_next = cnt_add;
                sum_next  = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// ----- hw/rtl/gst_queue.sv -----
// ----------------------------------------------------------------------------
// gst_queue
// Two-entry queue of group descriptors between front and back.
// ----------------------------------------------------------------------------
module gst_queue import gst_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  desc_t      push_desc,
    input  logic       pop,
    output desc_t      head,
    output logic       q_valid,
    output logic       q_full,
    output logic [1:0] level
);

    desc_t      ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] lvl_reg, lvl_next;

    assign head    = ent_reg[rp_reg];
    assign q_valid = lvl_reg != 2'd0;
    assign q_full  = lvl_reg == 2'd2;
    assign level   = lvl_reg;

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        lvl_next = lvl_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            lvl_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            lvl_reg <= lvl_next;
        end
    end

endmodule

// ----- hw/rtl/gst_back.sv -----
// ----------------------------------------------------------------------------
// gst_back
// Per group: bit-serial square root, restoring division for the shrink
// factor, then reads back each element and scales it.
// ----------------------------------------------------------------------------
module gst_back import gst_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [TH_W-1:0]          threshold,
    input  logic                     q_valid,
    input  desc_t                    head,
    output logic                     pop,
    output logic                     buf_re,
    output logic [ADDR_W-1:0]        buf_raddr,
    input  logic [DATA_W-1:0]        buf_rdata,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] scaled,
    output logic                     last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]        st_reg, st_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  res_reg, res_next;
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic [NORM_W:0]   drem_reg, drem_next;
    logic              dlow_reg, dlow_next;
    logic [4:0]        step_reg, step_next;
    logic [FACT_W-1:0] fact_reg, fact_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic signed [DATA_W-1:0] scaled_reg, scaled_next;
    logic              last_reg, last_next;

    logic [SUM_W:0]      trial;
    logic [NORM_W-1:0]   norm;
    logic [NORM_W-1:0]   diff;
    logic [NORM_W:0]     shifted;
    logic signed [DATA_W+FACT_W:0] prod;
    logic signed [DATA_W+FACT_W:0] rnd;
    logic                is_last;

    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign norm    = res_reg[NORM_W-1:0];
    assign diff    = norm - NORM_W'(threshold);
    assign shifted = {drem_reg[NORM_W-1:0], (step_reg == '0) ? dlow_reg : 1'b0};
    assign prod    = $signed(buf_rdata) * $signed({1'b0, fact_reg});
    assign rnd     = (prod + (DATA_W+FACT_W+1)'(32768)) >>> 16;
    assign is_last = ({1'b0, k_reg} + CNT_W'(1)) == head.cnt;

    assign buf_re    = st_reg == ST_READ;
    assign buf_raddr = {head.bank, k_reg};
    assign out_valid = st_reg == ST_HOLD;
    assign scaled    = scaled_reg;
    assign last      = last_reg;
    assign pop       = out_valid && out_ready && last_reg;

    always_comb
    begin
        st_next     = st_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        drem_next   = drem_reg;
        dlow_next   = dlow_reg;
        step_next   = step_reg;
        fact_next   = fact_reg;
        k_next      = k_reg;
        scaled_next = scaled_reg;
        last_next   = last_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    rem_next = head.sum;
                    res_next = '0;
                    bit_next = SUM_W'(1) << (SUM_W - 1);
                    k_next   = '0;
                    st_next  = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (trial <= {1'b0, rem_reg})
                    begin
                        rem_next = rem_reg - trial[SUM_W-1:0];
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                else if (norm == '0 || NORM_W'(threshold) >= norm)
                begin
                    fact_next = '0;
                    st_next   = ST_READ;
                end
                else
                begin
                    // quotient fits 17 bits: seed remainder with the top dividend bits
                    drem_next = (NORM_W+1)'(diff >> 1);
                    dlow_next = diff[0];
                    step_next = '0;
                    fact_next = '0;
                    st_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (shifted >= {1'b0, norm})
                begin
                    drem_next = shifted - {1'b0, norm};
                    fact_next = {fact_reg[FACT_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = shifted;
                    fact_next = {fact_reg[FACT_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(FACT_W - 1))
                    st_next = ST_READ;
            end
            ST_READ:
            begin
                st_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                scaled_next = rnd[DATA_W-1:0];
                last_next   = is_last;
                st_next     = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                        st_next = ST_IDLE;
                    else
                    begin
                        k_next  = k_reg + IDX_W'(1);
                        st_next = ST_READ;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        drem_reg   <= drem_next;
        dlow_reg   <= dlow_next;
        step_reg   <= step_next;
        fact_reg   <= fact_next;
        k_reg      <= k_next;
        scaled_reg <= scaled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            last_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            last_reg <= last_next;
        end
    end

endmodule

// ----- hw/rtl/group_soft_threshold_unit.sv -----
// ----------------------------------------------------------------------------
// group_soft_threshold_unit
// Group soft-thresholding of signed Q8.16 elements.
// ----------------------------------------------------------------------------
// Input: one element per cycle while a descriptor slot is free (two banks).
// Per group: a launch state, a bit-serial square root, a threshold check, then
// a restoring division when the norm exceeds the threshold; each element then
// passes buffer read, scale and transaction states, the transaction waiting on
// out_ready, before the next is read; the next group fills the other bank.
// Reset clears control state and config registers; buffer contents stay undefined.
module group_soft_threshold_unit import gst_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] scaled,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    logic [TH_W-1:0] threshold_reg;
    logic [GS_W-1:0] group_size_reg;

    logic              q_full, q_valid, push, pop;
    logic [1:0]        q_level;
    desc_t             push_desc, head;
    logic              buf_we, buf_re;
    logic [ADDR_W-1:0] buf_waddr, buf_raddr;
    logic [DATA_W-1:0] buf_wdata, buf_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            group_size_reg <= GS_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_THRESHOLD)
                threshold_reg <= cfg_data[TH_W-1:0];
            else if (cfg_index == REG_GROUP_SIZE)
                group_size_reg <= cfg_data[GS_W-1:0];
        end
    end

    gst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .group_size (group_size_reg),
        .q_full     (q_full),
        .push       (push),
        .push_desc  (push_desc),
        .buf_we     (buf_we),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata)
    );

    gst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .level     (q_level)
    );

    gst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    gst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .buf_re    (buf_re),
        .buf_raddr (buf_raddr),
        .buf_rdata (buf_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scaled    (scaled),
        .last      (last)
    );

    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != 2'd3)
        else $error("descriptor queue overflow");

    a_out_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> q_level != 2'd0)
        else $error("result without a pending group");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_level != 2'd2 || pop)
        else $error("group completed into a full queue");

    a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> q_level == $past(q_level) - 2'd1)
        else $error("queue level did not drop after group end");

endmodule
